// ===== src/ufq_pkg.sv =====
// Shared types and codes for the duplicate-rejecting FIFO queue.
package ufq_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int STS_W  = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

   // result status codes
   localparam logic [STS_W-1:0] STS_INSERTED   = 3'd0;
   localparam logic [STS_W-1:0] STS_DUPLICATE  = 3'd1;
   localparam logic [STS_W-1:0] STS_FULL       = 3'd2;
   localparam logic [STS_W-1:0] STS_REMOVED    = 3'd3;
   localparam logic [STS_W-1:0] STS_EMPTY      = 3'd4;
   localparam logic [STS_W-1:0] STS_LISTED     = 3'd5;
   localparam logic [STS_W-1:0] STS_LIST_EMPTY = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_LIST   = 4'b0100,
      ST_RESULT = 4'b1000
   } ufq_state_type;

   // result offered by the sequencer to the output register
   typedef struct packed {
      logic              valid;
      logic [STS_W-1:0]  status;
      logic [DATA_W-1:0] data;
      logic              last;
   } ufq_rsp_type;

   // occupancy flags
   typedef struct packed {
      logic empty;
      logic full;
   } ufq_stat_type;

endpackage

// ===== src/ufq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ufq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/ufq_seq.sv =====
// Sequencer: ring pointers, duplicate scan, list walk and result selection.
module ufq_seq #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ufq_pkg::OP_W-1:0]            req_operation,
   input  logic signed [ufq_pkg::DATA_W-1:0]   req_value,
   input  logic                                out_free,
   output ufq_pkg::ufq_rsp_type                emit,
   output ufq_pkg::ufq_stat_type               stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ufq_pkg::ufq_state_type state_ff, state_in;

   logic [ufq_pkg::OP_W-1:0]   op_ff, op_in;
   logic [ufq_pkg::DATA_W-1:0] value_ff, value_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [PTR_W-1:0]           scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]           issue_cnt_ff, issue_cnt_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic                       dup_ff, dup_in;

   logic                       rd_en;
   logic [PTR_W-1:0]           rd_addr;
   logic [ufq_pkg::DATA_W-1:0] rd_data;
   logic                       wr_en;

   logic is_empty;
   logic is_full;
   logic issue_more;
   logic match;
   logic list_issue;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   ufq_ram #(
      .WIDTH (ufq_pkg::DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign issue_more = (issue_cnt_ff != count_ff);
   assign match      = rd_valid_ff && (rd_data == value_ff);
   // next list read only once the held entry is gone or leaving
   assign list_issue = issue_more && (!rd_valid_ff || out_free);

   assign stat.empty = is_empty;
   assign stat.full  = is_full;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_valid_in  = rd_valid_ff;
      dup_in       = dup_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ptr_ff;
      wr_en        = 1'b0;
      req_ready    = 1'b0;
      emit         = '0;

      unique case (state_ff)
         ufq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in        = req_operation;
               value_in     = req_value;
               scan_ptr_in  = head_ff;
               issue_cnt_in = '0;
               rd_valid_in  = 1'b0;
               dup_in       = 1'b0;
               unique case (req_operation)
                  ufq_pkg::OP_INSERT: begin
                     state_in = ufq_pkg::ST_SCAN;
                  end
                  ufq_pkg::OP_REMOVE: begin
                     rd_en    = !is_empty;
                     rd_addr  = head_ff;
                     state_in = ufq_pkg::ST_RESULT;
                  end
                  ufq_pkg::OP_LIST: begin
                     state_in = is_empty ? ufq_pkg::ST_RESULT : ufq_pkg::ST_LIST;
                  end
                  default: begin
                     state_in = ufq_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         ufq_pkg::ST_SCAN: begin
            // reads are pipelined: compare of entry n overlaps read of n+1
            priority if (match) begin
               dup_in   = 1'b1;
               state_in = ufq_pkg::ST_RESULT;
            end else if (!issue_more && !rd_valid_ff) begin
               state_in = ufq_pkg::ST_RESULT;
            end else begin
               rd_valid_in = issue_more;
               if (issue_more) begin
                  rd_en        = 1'b1;
                  scan_ptr_in  = next_ptr(scan_ptr_ff);
                  issue_cnt_in = issue_cnt_ff + 1'b1;
               end
            end
         end

         ufq_pkg::ST_LIST: begin
            emit.valid  = rd_valid_ff;
            emit.status = ufq_pkg::STS_LISTED;
            emit.data   = rd_data;
            emit.last   = !issue_more;
            rd_valid_in = list_issue || (rd_valid_ff && !out_free);
            if (list_issue) begin
               rd_en        = 1'b1;
               scan_ptr_in  = next_ptr(scan_ptr_ff);
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (rd_valid_ff && out_free && !issue_more) begin
               state_in = ufq_pkg::ST_IDLE;
            end
         end

         ufq_pkg::ST_RESULT: begin
            emit.valid = 1'b1;
            emit.last  = 1'b1;
            unique case (op_ff)
               ufq_pkg::OP_INSERT: begin
                  emit.data = value_ff;
                  priority if (dup_ff) begin
                     emit.status = ufq_pkg::STS_DUPLICATE;
                  end else if (is_full) begin
                     emit.status = ufq_pkg::STS_FULL;
                  end else begin
                     emit.status = ufq_pkg::STS_INSERTED;
                     if (out_free) begin
                        wr_en    = 1'b1;
                        tail_in  = next_ptr(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               ufq_pkg::OP_REMOVE: begin
                  if (is_empty) begin
                     emit.status = ufq_pkg::STS_EMPTY;
                  end else begin
                     emit.status = ufq_pkg::STS_REMOVED;
                     emit.data   = rd_data;
                     if (out_free) begin
                        head_in  = next_ptr(head_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
               ufq_pkg::OP_LIST: begin
                  emit.status = ufq_pkg::STS_LIST_EMPTY;
               end
               default: begin
                  emit.valid = 1'b0;
               end
            endcase
            if (out_free) begin
               state_in = ufq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ufq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ufq_pkg::ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
         dup_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
         dup_ff      <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      scan_ptr_ff  <= scan_ptr_in;
      issue_cnt_ff <= issue_cnt_in;
   end

endmodule

// ===== src/unique_fifo_queue.sv =====
// Top level: duplicate-rejecting FIFO queue with a registered result port.
//
//   channel   dir  handshake              payload
//   req_      in   req_valid/req_ready    operation, value
//   rsp_      out  rsp_valid/rsp_ready    status, data, last
//
// One item at a time. An insert scans the held entries for a duplicate and a
// list walks them in order, streaming results while the result port takes
// them; the single read port of the ring RAM reads the entries one by one.
// Reset clears head, tail and count; ring contents are never cleared.
// A stalled result port holds the sequencer; a new item is taken while the
// last result still waits in the output register.
module unique_fifo_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ufq_pkg::OP_W-1:0]           req_operation,
   input  logic signed [ufq_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ufq_pkg::STS_W-1:0]          rsp_status,
   output logic signed [ufq_pkg::DATA_W-1:0]  rsp_data,
   output logic                               rsp_last
);

   ufq_pkg::ufq_rsp_type  emit;
   ufq_pkg::ufq_stat_type stat;

   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ufq_pkg::STS_W-1:0]  rsp_status_ff;
   logic [ufq_pkg::DATA_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;

   ufq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .out_free      (out_free),
      .emit          (emit),
      .stat          (stat)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = out_free ? emit.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid && out_free) begin
         rsp_status_ff <= emit.status;
         rsp_data_ff   <= emit.data;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = $signed(rsp_data_ff);
   assign rsp_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   // a meaningful item leaves the block busy, so req_ready drops
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == ufq_pkg::OP_INSERT ||
       req_operation == ufq_pkg::OP_REMOVE || req_operation == ufq_pkg::OP_LIST))
      |=> !req_ready)
      else $error("block took a new item right after a real one");

   a_count_sane: assert property (@(posedge clock) disable iff (reset)
      !(stat.empty && stat.full))
      else $error("queue both empty and full");

   a_data_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && (emit.status == ufq_pkg::STS_REMOVED ||
       emit.status == ufq_pkg::STS_LISTED)) |-> !stat.empty)
      else $error("entry result from an empty queue");

   a_insert_has_room: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.status == ufq_pkg::STS_INSERTED) |-> !stat.full)
      else $error("insert into a full queue");

   a_multi_only_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> rsp_status == ufq_pkg::STS_LISTED)
      else $error("non-final result outside a list");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the duplicate-rejecting FIFO queue.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int LIMIT       = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 64;
   localparam int PHASE_ITEMS = 76;
   localparam logic [ufq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [ufq_pkg::OP_W-1:0]          op_type;
   typedef logic [ufq_pkg::STS_W-1:0]         sts_type;
   typedef logic signed [ufq_pkg::DATA_W-1:0] data_type;

   typedef struct {
      sts_type  status;
      data_type data;
      logic     last;
   } qresult_type;

   // Predicts queue answers and checks them in order of arrival.
   class queue_scoreboard;
      data_type    ring [DEPTH];
      int          head;
      int          tail;
      int          count;
      qresult_type awaited [$];
      int          mismatches;
      int          checked;
      int          n_insert, n_remove, n_list, n_ignored;
      int          n_full, n_dup, n_empty, n_full_list;

      function new();
         head = 0;
         tail = 0;
         count = 0;
         mismatches = 0;
         checked = 0;
         n_insert = 0; n_remove = 0; n_list = 0; n_ignored = 0;
         n_full = 0; n_dup = 0; n_empty = 0; n_full_list = 0;
      endfunction

      function void push(sts_type s, data_type d, logic l);
         qresult_type r;
         r.status = s;
         r.data   = d;
         r.last   = l;
         awaited.push_back(r);
      endfunction

      // accepted input item: update the queue copy and queue up its answers
      function void note_item(op_type op, data_type val);
         bit hit;
         int idx;
         hit = 0;
         case (op)
            ufq_pkg::OP_INSERT: begin
               n_insert++;
               idx = head;
               for (int n = 0; n < count; n++) begin
                  if (ring[idx] == val) hit = 1;
                  idx = (idx + 1) % DEPTH;
               end
               if (hit) begin
                  n_dup++;
                  push(ufq_pkg::STS_DUPLICATE, val, 1'b1);
               end else if (count == DEPTH) begin
                  n_full++;
                  push(ufq_pkg::STS_FULL, val, 1'b1);
               end else begin
                  ring[tail] = val;
                  tail = (tail + 1) % DEPTH;
                  count++;
                  push(ufq_pkg::STS_INSERTED, val, 1'b1);
               end
            end
            ufq_pkg::OP_REMOVE: begin
               n_remove++;
               if (count == 0) begin
                  n_empty++;
                  push(ufq_pkg::STS_EMPTY, '0, 1'b1);
               end else begin
                  push(ufq_pkg::STS_REMOVED, ring[head], 1'b1);
                  head = (head + 1) % DEPTH;
                  count--;
               end
            end
            ufq_pkg::OP_LIST: begin
               n_list++;
               if (count == 0) begin
                  n_empty++;
                  push(ufq_pkg::STS_LIST_EMPTY, '0, 1'b1);
               end else begin
                  if (count == DEPTH) n_full_list++;
                  idx = head;
                  for (int n = 0; n < count; n++) begin
                     push(ufq_pkg::STS_LISTED, ring[idx], (n + 1 == count));
                     idx = (idx + 1) % DEPTH;
                  end
               end
            end
            default: n_ignored++;
         endcase
      endfunction

      function void check_result(sts_type s, data_type d, logic l);
         qresult_type e;
         checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d data %0d last %0b", s, d, l);
            return;
         end
         e = awaited.pop_front();
         if (s !== e.status || d !== e.data || l !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at result %0d: expected status %0d data %0d last %0b",
                        checked, e.status, e.data, e.last);
               $display("   got status %0d data %0d last %0b", s, d, l);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   op_type   req_operation;
   data_type req_value;
   logic     rsp_valid;
   logic     rsp_ready;
   sts_type  rsp_status;
   data_type rsp_data;
   logic     rsp_last;

   queue_scoreboard sb = new();
   int  cycle_count = 0;
   int  stall_pct = 0;
   int  send_idle = 0;
   // long hold-off: the sender bumps hold_req, the receiver catches up
   int  hold_req = 0;
   int  hold_seen = 0;

   unique_fifo_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_last      (rsp_last)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("end of test: mismatches");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rsp_ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_data, rsp_last);
   end

   task automatic send_item(op_type op, data_type val);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(op, val);
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // small pool makes duplicates common; the rest spreads over all bits
   function automatic data_type pick_value();
      int p;
      p = $urandom_range(99);
      if (p < 45) return $urandom_range(23);
      if (p < 50) return 32'sh8000_0000;
      if (p < 55) return 32'sh7fff_ffff;
      if (p < 60) return -32'sd1;
      return $urandom;
   endfunction

   // mode 0 fills, mode 1 drains, mode 2 mixes
   function automatic op_type choose_op(int mode);
      int p;
      p = $urandom_range(99);
      if (p < 4) return OP_UNUSED;
      case (mode)
         0: begin
            if (p < 80) return ufq_pkg::OP_INSERT;
            if (p < 92) return ufq_pkg::OP_REMOVE;
         end
         1: begin
            if (p < 25) return ufq_pkg::OP_INSERT;
            if (p < 85) return ufq_pkg::OP_REMOVE;
         end
         default: begin
            if (p < 50) return ufq_pkg::OP_INSERT;
            if (p < 80) return ufq_pkg::OP_REMOVE;
         end
      endcase
      return ufq_pkg::OP_LIST;
   endfunction

   task automatic run_random(int target);
      int done;
      int mode;
      int burst;
      op_type op;
      done = 0;
      while (done < target) begin
         mode  = $urandom_range(2);
         burst = $urandom_range(4, 20);
         for (int k = 0; k < burst && done < target; k++) begin
            op = choose_op(mode);
            sender_gap();
            send_item(op, (op == ufq_pkg::OP_INSERT) ? pick_value() : $urandom);
            if (op != OP_UNUSED) done++;
         end
      end
   endtask

   initial begin
      int failures;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = ufq_pkg::OP_INSERT;
      req_value     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty answers, ignored code, extremes, duplicate, full queue
      send_item(ufq_pkg::OP_REMOVE, 32'sh5a5a_5a5a);
      send_item(ufq_pkg::OP_LIST, -32'sd1);
      send_item(OP_UNUSED, 32'sh7fff_ffff);
      send_item(ufq_pkg::OP_INSERT, 32'sh8000_0000);
      send_item(ufq_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_item(ufq_pkg::OP_INSERT, 32'sd0);
      send_item(ufq_pkg::OP_INSERT, -32'sd1);
      send_item(ufq_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_item(ufq_pkg::OP_LIST, 32'sd0);
      send_item(ufq_pkg::OP_REMOVE, 32'sd0);
      for (int k = 0; k < 13; k++) send_item(ufq_pkg::OP_INSERT, 32'sd100 + k);
      send_item(ufq_pkg::OP_INSERT, 32'sd999);
      send_item(ufq_pkg::OP_INSERT, 32'sd100);
      send_item(ufq_pkg::OP_LIST, 32'sd0);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0;  stall_pct <= 0;  end
            1: begin send_idle = 88; stall_pct <= 0;  end
            2: begin send_idle = 0;  stall_pct <= 88; end
            default: begin send_idle = 20; stall_pct <= 20; end
         endcase
         run_random(PHASE_ITEMS);
         if (ph == 0) begin
            // result side blocked while the sender keeps offering items
            hold_req++;
            for (int k = 0; k < 24; k++) send_item(ufq_pkg::OP_INSERT, pick_value());
            send_item(ufq_pkg::OP_LIST, $urandom);
         end
         wait_drained();
      end

      stall_pct <= 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      failures = sb.mismatches + sb.pending();
      if (sb.pending() != 0)
         $display("%0d expected results never arrived", sb.pending());
      $display("ran %0d inserts, %0d removes, %0d lists, %0d ignored codes; %0d results checked",
               sb.n_insert, sb.n_remove, sb.n_list, sb.n_ignored, sb.checked);
      $display("full refusals %0d, duplicates %0d, empty answers %0d, full-queue lists %0d",
               sb.n_full, sb.n_dup, sb.n_empty, sb.n_full_list);
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
